// ===== rtl/bae_pkg.sv =====
`default_nettype none

package bae_pkg;

  // longest counted 0xff run before bytes are lost
  localparam int unsigned MaxOutstanding = 32;
  localparam int unsigned RunW = $clog2(MaxOutstanding + 1);

  // release command queue between front and back end
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  // coder state after reset
  localparam logic [7:0]        RangeReset = 8'hff;
  localparam logic signed [4:0] QueueBitsReset = -5'sd9;

  // operation codes
  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DRAIN  = 1'b1
  } op_e;

  // input transaction
  typedef struct packed {
    logic       operation;
    logic [7:0] prob;
    logic       bit_req;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       run_overflow;
  } out_t;

  // one release: optional held byte, then a run of fill bytes
  typedef struct packed {
    logic            held_en;
    logic [7:0]      held_byte;
    logic [RunW-1:0] run_len;
    logic            fill_ff;
    logic            ovf;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bae_fifo.sv =====
`default_nettype none

module bae_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  bae_pkg::cmd_t   data_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            empty_o,
  output bae_pkg::cmd_t   data_o
);

  bae_pkg::cmd_t                       mem_q [bae_pkg::QueueDepth];
  logic [bae_pkg::QueuePtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [bae_pkg::QueuePtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [bae_pkg::QueueCntW-1:0]       count_q, count_d;

  assign full_o  = (count_q == bae_pkg::QueueCntW'(bae_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // no overrun, no underrun, count within depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("release queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("release queue read while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bae_pkg::QueueCntW'(bae_pkg::QueueDepth))
    else $error("release queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("release queue lost a pushed command");

endmodule

`default_nettype wire

// ===== rtl/bae_front.sv =====
`default_nettype none

module bae_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  bae_pkg::in_t    in_data_i,
  input  wire             q_full_i,
  output logic            push_o,
  output bae_pkg::cmd_t   cmd_o
);

  logic [23:0]                  low_q, low_d;
  logic [7:0]                   range_q, range_d;
  logic signed [4:0]            qbits_q, qbits_d;
  logic [bae_pkg::RunW-1:0]     count_q, count_d;
  logic [7:0]                   held_q, held_d;
  logic                         held_valid_q, held_valid_d;
  logic                         lost_q, lost_d;

  logic                         accept;
  logic                         has_cmd;
  logic [15:0]                  prod;
  logic [7:0]                   split;
  logic [23:0]                  low_sum;
  logic [7:0]                   rng;
  logic [2:0]                   shift;
  logic [23:0]                  low_sh;
  logic signed [4:0]            qsum;
  logic [2:0]                   q;
  logic [23:0]                  byte_word;
  logic [7:0]                   byte_val;
  logic                         carry;

  // leading zeros of a non-zero byte
  function automatic logic [2:0] lzc8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        n = 3'(7 - i);
      end
    end
    return n;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // interval split and renormalisation
  always_comb begin
    prod  = 16'(range_q - 8'd1) * 16'(in_data_i.prob);
    split = 8'd1 + prod[15:8];
    if (in_data_i.bit_req) begin
      low_sum = low_q + 24'(split);
      rng     = range_q - split;
    end else begin
      low_sum = low_q;
      rng     = split;
    end
    if (rng == 8'd0) begin
      rng = 8'd1;
    end
    shift     = lzc8(rng);
    low_sh    = low_sum << shift;
    qsum      = qbits_q + $signed({2'b00, shift});
    q         = qsum[2:0];
    byte_word = low_sh >> (5'(q) + 5'd10);
    byte_val  = byte_word[7:0];
    carry     = byte_word[8];
  end

  // state update and release command
  always_comb begin
    low_d        = low_q;
    range_d      = range_q;
    qbits_d      = qbits_q;
    count_d      = count_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    lost_d       = lost_q;
    has_cmd      = 1'b0;
    cmd_o.held_en   = held_valid_q;
    cmd_o.held_byte = held_q;
    cmd_o.run_len   = count_q;
    cmd_o.fill_ff   = 1'b1;
    cmd_o.ovf       = lost_q;
    if (accept) begin
      case (bae_pkg::op_e'(in_data_i.operation))
        bae_pkg::OP_DRAIN: begin
          has_cmd      = held_valid_q || (count_q != '0);
          count_d      = '0;
          lost_d       = 1'b0;
          held_valid_d = 1'b0;
        end
        bae_pkg::OP_ENCODE: begin
          range_d = rng << shift;
          low_d   = low_sh;
          qbits_d = qsum;
          if (!qsum[4]) begin
            low_d   = low_sh & ((24'h400 << q) - 24'd1);
            qbits_d = qsum - 5'sd8;
            if (byte_val == 8'hff) begin
              if (count_q < bae_pkg::RunW'(bae_pkg::MaxOutstanding)) begin
                count_d = count_q + 1'b1;
              end else begin
                lost_d = 1'b1;
              end
            end else begin
              has_cmd         = held_valid_q || (count_q != '0);
              cmd_o.held_byte = held_q + 8'(carry);
              cmd_o.fill_ff   = !carry;
              count_d         = '0;
              lost_d          = 1'b0;
              held_d          = byte_val;
              held_valid_d    = 1'b1;
            end
          end
        end
        default: begin
          has_cmd = 1'b0;
        end
      endcase
    end
  end

  assign push_o = accept && has_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q        <= '0;
      range_q      <= bae_pkg::RangeReset;
      qbits_q      <= bae_pkg::QueueBitsReset;
      count_q      <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      lost_q       <= 1'b0;
    end else begin
      low_q        <= low_d;
      range_q      <= range_d;
      qbits_q      <= qbits_d;
      count_q      <= count_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      lost_q       <= lost_d;
    end
  end

  // range stays normalised, bit queue in bounds, run never past bound
  assert property (@(posedge clk_i) disable iff (!rst_ni) range_q[7])
    else $error("range not normalised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qbits_q >= -5'sd9) && (qbits_q <= -5'sd1))
    else $error("bit queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bae_pkg::RunW'(bae_pkg::MaxOutstanding))
    else $error("outstanding run past bound");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_q |-> (count_q == bae_pkg::RunW'(bae_pkg::MaxOutstanding)))
    else $error("run overflow without full run");

endmodule

`default_nettype wire

// ===== rtl/bae_back.sv =====
`default_nettype none

module bae_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             q_empty_i,
  input  bae_pkg::cmd_t   cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output bae_pkg::out_t   out_data_o
);

  logic                         active_q, active_d;
  logic                         held_pend_q, held_pend_d;
  logic [7:0]                   held_q, held_d;
  logic [bae_pkg::RunW-1:0]     cnt_q, cnt_d;
  logic                         fill_ff_q, fill_ff_d;
  logic                         ovf_q, ovf_d;
  logic                         out_valid_q, out_valid_d;
  bae_pkg::out_t                out_q, out_d;
  logic                         slot_free;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = !active_q && !q_empty_i;

  // expand one release command into bytes, one a cycle while the output slot is free
  always_comb begin
    active_d    = active_q;
    held_pend_d = held_pend_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    fill_ff_d   = fill_ff_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      active_d    = 1'b1;
      held_pend_d = cmd_i.held_en;
      held_d      = cmd_i.held_byte;
      cnt_d       = cmd_i.run_len;
      fill_ff_d   = cmd_i.fill_ff;
      ovf_d       = cmd_i.ovf;
    end else if (active_q && slot_free) begin
      out_valid_d        = 1'b1;
      out_d.run_overflow = ovf_q;
      if (held_pend_q) begin
        out_d.out_byte = held_q;
        out_d.last     = (cnt_q == '0);
        held_pend_d    = 1'b0;
        active_d       = (cnt_q != '0);
      end else begin
        out_d.out_byte = fill_ff_q ? 8'hff : 8'h00;
        out_d.last     = (cnt_q == bae_pkg::RunW'(1));
        cnt_d          = cnt_q - 1'b1;
        active_d       = (cnt_q != bae_pkg::RunW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      held_pend_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      held_pend_q <= held_pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    held_q    <= held_d;
    fill_ff_q <= fill_ff_d;
    ovf_q     <= ovf_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an active command always has a byte left, a waiting byte holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (held_pend_q || (cnt_q != '0)))
    else $error("active release with nothing to send");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("waiting output transaction changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> active_q)
    else $error("popped command not loaded");

endmodule

`default_nettype wire

// ===== rtl/boolean_arithmetic_encoder.sv =====
// Boolean arithmetic (VP8 style) encoder. Each input transaction either codes one binary
// decision with an 8-bit probability of zero or drains the held byte and the outstanding
// 0xff run. The front end takes one transaction per cycle whenever the four-entry release
// queue has room; the split (one 8x8 multiply), renormalisation and byte extraction are
// done in that cycle. Releases go through the queue to the back end, which loads a release
// only once the previous one is sent and then emits its bytes one after another, each when
// the output slot is free; the back end's byte rate sets the sustained throughput when
// bytes are dense. last marks the final byte caused by a transaction, run_overflow marks
// every byte of a release whose 0xff run passed 32 bytes. A flush is 32 zero decisions
// at prob 128 followed by one drain. No clearing pass is needed after reset.
`default_nettype none

module boolean_arithmetic_encoder (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  bae_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output bae_pkg::out_t   out_data_o
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  bae_pkg::cmd_t  cmd_in;
  bae_pkg::cmd_t  cmd_out;

  // decision coding and release generation
  bae_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  // release queue
  bae_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (cmd_out)
  );

  // byte output
  bae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== test/bae_byte_checker.sv =====
`timescale 1ns / 100ps

module bae_byte_checker (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  input  wire            in_ready_i,
  input  bae_pkg::in_t   in_data_i,
  input  wire            out_valid_i,
  input  wire            out_ready_i,
  input  bae_pkg::out_t  out_data_i,
  output int             mismatch_count_o,
  output int             bytes_awaited_o
);

  // shadow coder state
  logic [23:0]       coder_low;
  logic [7:0]        coder_range;
  logic signed [4:0] coder_qbits;
  logic [5:0]        ff_run;
  logic [7:0]        held_byte;
  logic              held_valid;
  logic              run_lost;

  // bytes predicted but not yet seen on the output
  bae_pkg::out_t coded_bytes[$];

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: mismatch on %s, expected %0h, got %0h", $realtime, what, want, got);
    mismatch_count_o++;
  endtask

  // held byte plus carry, then the counted 0xff run as fill bytes
  task automatic release_bytes(input logic carry);
    bae_pkg::out_t b;
    int            i;
    b.last         = 1'b0;
    b.run_overflow = run_lost;
    if (held_valid) begin
      b.out_byte = held_byte + {7'd0, carry};
      coded_bytes.push_back(b);
    end
    b.out_byte = carry ? 8'h00 : 8'hff;
    for (i = 0; i < ff_run; i++) begin
      coded_bytes.push_back(b);
    end
    ff_run     = '0;
    run_lost   = 1'b0;
    held_valid = 1'b0;
  endtask

  // one accepted transaction: code a decision or drain
  task automatic code_decision(input bae_pkg::in_t t);
    int unsigned   split;
    int unsigned   rng;
    int unsigned   shift;
    int unsigned   low;
    int unsigned   q;
    int unsigned   coded;
    int            qb;
    int            before_cnt;
    bae_pkg::out_t tail;
    before_cnt = coded_bytes.size();
    if (t.operation == bae_pkg::OP_DRAIN) begin
      release_bytes(1'b0);
    end else begin
      rng   = coder_range;
      low   = coder_low;
      shift = 0;
      split = 1 + (((rng - 1) * t.prob) >> 8);
      // a one takes the upper part of the interval
      if (t.bit_req) begin
        low = (low + split) & 32'h00ff_ffff;
        rng = rng - split;
      end else begin
        rng = split;
      end
      rng = rng & 32'hff;
      if (rng == 0) begin
        rng = 1;
      end
      // renormalise by leading zeros
      while (rng < 32'h80) begin
        rng = rng << 1;
        shift++;
      end
      low = (low << shift) & 32'h00ff_ffff;
      qb  = coder_qbits + int'(shift);
      // a full byte leaves the low register
      if (qb >= 0) begin
        q     = qb & 15;
        coded = low >> (q + 10);
        low   = low & ((32'h400 << q) - 1);
        qb    = qb - 8;
        if ((coded & 32'hff) == 32'hff) begin
          if (ff_run < bae_pkg::MaxOutstanding) begin
            ff_run++;
          end else begin
            run_lost = 1'b1;
          end
        end else begin
          release_bytes(((coded >> 8) & 1) != 0);
          held_byte  = coded[7:0];
          held_valid = 1'b1;
        end
      end
      coder_low   = low[23:0];
      coder_range = rng[7:0];
      coder_qbits = qb[4:0];
    end
    // flag the final byte of this transaction
    if (coded_bytes.size() > before_cnt) begin
      tail      = coded_bytes.pop_back();
      tail.last = 1'b1;
      coded_bytes.push_back(tail);
    end
  endtask

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    bae_pkg::out_t want;
    if (!rst_ni) begin
      coder_low        = '0;
      coder_range      = bae_pkg::RangeReset;
      coder_qbits      = bae_pkg::QueueBitsReset;
      ff_run           = '0;
      held_byte        = '0;
      held_valid       = 1'b0;
      run_lost         = 1'b0;
      coded_bytes.delete();
      mismatch_count_o = 0;
      bytes_awaited_o  = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        code_decision(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (coded_bytes.size() == 0) begin
          report_mismatch("byte with none awaited", 0, out_data_i.out_byte);
        end else begin
          want = coded_bytes.pop_front();
          if (out_data_i.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", want.out_byte, out_data_i.out_byte);
          end
          if (out_data_i.last !== want.last) begin
            report_mismatch("last", want.last, out_data_i.last);
          end
          if (out_data_i.run_overflow !== want.run_overflow) begin
            report_mismatch("run_overflow", want.run_overflow, out_data_i.run_overflow);
          end
        end
      end
      bytes_awaited_o = coded_bytes.size();
    end
  end

endmodule

// ===== test/tb_boolean_arithmetic_encoder.sv =====
`timescale 1ns / 100ps

module tb_boolean_arithmetic_encoder;

  // receiver stall patterns
  typedef enum int {
    READY_ALWAYS,
    STALL_RARE,
    STALL_PERIODIC,
    STALL_COIN
  } stall_e;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  bae_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  bae_pkg::out_t out_data;

  int mismatch_count;
  int bytes_awaited;
  int items_sent = 0;
  int burst_left = 1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  boolean_arithmetic_encoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  bae_byte_checker checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .bytes_awaited_o (bytes_awaited)
  );

  // offer one transaction, then maybe pause after the burst
  task automatic send_coder_item(input bae_pkg::op_e op_code, input logic [7:0] p_zero,
                                 input logic decision);
    bae_pkg::in_t t;
    t.operation = op_code;
    t.prob      = p_zero;
    t.bit_req   = decision;
    in_data  <= t;
    in_valid <= 1'b1;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
    end
  endtask

  // 32 zero decisions at even odds, then a drain
  task automatic flush_coder();
    int i;
    for (i = 0; i < 32; i++) begin
      send_coder_item(bae_pkg::OP_ENCODE, 8'd128, 1'b0);
    end
    send_coder_item(bae_pkg::OP_DRAIN, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
  endtask

  // unlikely ones in a row push out long 0xff runs
  task automatic ff_run_burst(input logic [7:0] p_zero, input int span);
    int i;
    for (i = 0; i < span; i++) begin
      send_coder_item(bae_pkg::OP_ENCODE, p_zero, 1'b1);
    end
  endtask

  // sender
  initial begin : stimulus
    int          span;
    int          i;
    int          pick;
    int          target;
    logic [7:0]  p;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: drain on an empty coder, probability extremes, drains
    send_coder_item(bae_pkg::OP_DRAIN,  8'h00, 1'b0);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h00, 1'b0);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h00, 1'b1);
    send_coder_item(bae_pkg::OP_ENCODE, 8'hff, 1'b0);
    send_coder_item(bae_pkg::OP_ENCODE, 8'hff, 1'b1);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h80, 1'b1);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h80, 1'b0);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h01, 1'b1);
    send_coder_item(bae_pkg::OP_ENCODE, 8'hfe, 1'b0);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h55, 1'b1);
    send_coder_item(bae_pkg::OP_ENCODE, 8'haa, 1'b0);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h00, 1'b1);
    send_coder_item(bae_pkg::OP_ENCODE, 8'hff, 1'b1);
    send_coder_item(bae_pkg::OP_DRAIN,  8'hff, 1'b1);
    send_coder_item(bae_pkg::OP_DRAIN,  8'h00, 1'b0);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h00, 1'b0);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h7f, 1'b1);
    send_coder_item(bae_pkg::OP_ENCODE, 8'h00, 1'b0);
    send_coder_item(bae_pkg::OP_DRAIN,  8'h00, 1'b1);

    // a run long enough to pass the bound
    target = 410;
    ff_run_burst(8'hff, 48);

    // random mix of sequences
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        span = $urandom_range(5, 30);
        for (i = 0; i < span; i++) begin
          send_coder_item(bae_pkg::OP_ENCODE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
      end else if (pick < 55) begin
        // decisions that follow their own probability
        p    = 8'($urandom_range(0, 255));
        span = $urandom_range(10, 40);
        for (i = 0; i < span; i++) begin
          send_coder_item(bae_pkg::OP_ENCODE, p, $urandom_range(0, 255) >= p);
        end
      end else if (pick < 70) begin
        ff_run_burst(8'($urandom_range(248, 255)), $urandom_range(36, 56));
      end else if (pick < 80) begin
        flush_coder();
      end else begin
        span = $urandom_range(1, 8);
        for (i = 0; i < span; i++) begin
          send_coder_item(($urandom_range(0, 3) == 0) ? bae_pkg::OP_DRAIN
                                                      : bae_pkg::OP_ENCODE,
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
    in_valid <= 1'b0;

    // let the coded stream run dry
    @(negedge clk);
    while (bytes_awaited != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: stall patterns plus one long hold-off
  initial begin : receiver
    stall_e mode;
    int     span;
    int     cycles;
    bit     holdoff_done;
    logic   rdy;
    cycles       = 0;
    holdoff_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      mode = stall_e'($urandom_range(0, 3));
      span = $urandom_range(8, 60);
      repeat (span) begin
        case (mode)
          READY_ALWAYS:   rdy = 1'b1;
          STALL_RARE:     rdy = ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: rdy = ((cycles % 4) != 3);
          default:        rdy = 1'($urandom_range(0, 1));
        endcase
        out_ready <= rdy;
        @(posedge clk);
        cycles++;
      end
      // back the coder up until its input stalls
      if (!holdoff_done && cycles >= 150) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        cycles       = cycles + 300;
        holdoff_done = 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
